[hw/rtl/assert_macros.svh]
// assertion macros included by mfb_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CHK_HOLDS(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// condition in one cycle implies an expression in the next
`define CHK_NEXT(label, ck, rn, cond, expr, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (expr)) \
        else $error(msg);

`endif

[hw/rtl/mfb_pkg.sv]
// shared types, codes and tables of the framebuffer draw engine
package mfb_pkg;

    localparam int DISP_WIDTH_DEF  = 128;
    localparam int DISP_HEIGHT_DEF = 32;

    // coordinates on the display always fit in eight bits (at most 256 per side)
    localparam int COORD_W = 8;
    localparam int PAGE_W  = COORD_W - 3;
    // signed width for unclipped span arithmetic
    localparam int SPAN_W  = 12;

    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_RECT  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] COLOR_BLACK  = 2'd0;
    localparam logic [1:0] COLOR_WHITE  = 2'd1;
    localparam logic [1:0] COLOR_INVERT = 2'd2;
    localparam logic [1:0] COLOR_NONE   = 2'd3;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic REG_IDX_ROTATION = 1'b0;

    localparam logic [7:0] FULL_MASK = 8'hFF;

    // low k bits set
    localparam logic [7:0] LOW_MASK [0:7] = '{
        8'h00, 8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F
    };

    typedef struct packed {
        logic [1:0] req_type;
        logic [8:0] x_pos;
        logic [8:0] y_pos;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
        logic [1:0] color;
        logic [8:0] byte_index;
    } item_t;

    typedef struct packed {
        logic load_en;
        logic range_en;
        logic clip_en;
        logic walk_en;
        logic rd_en;
        logic clr_en;
        logic res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic walk_last;
        logic clr_last;
    } dp_status_t;

    typedef struct packed {
        logic rd_en;
        logic rmw_en;
        logic clr_en;
    } store_ctl_t;

endpackage

[hw/rtl/mono_framebuffer_draw_engine.sv]
// top level of the page-organized monochrome framebuffer draw engine
//
// channel  direction  handshake            contents
// s_*      in         s_tvalid / s_tready  draw request item
// m_*      out        m_tvalid / m_tready  result item
// apb      in         psel/penable/pready  rotation register (reg 0 at byte 0)
//
// one item at a time; a pixel or rectangle passes RANGE, CLIP, WALK (one read-modify-write
// of the store per touched byte), DRAIN and FINISH; an empty or fully clipped rectangle skips
// WALK and DRAIN; a read passes READ and FINISH; a clear sweeps the store in CLEAR, then FINISH
// after reset a zero-fill pass over all DISP_WIDTH*ceil(DISP_HEIGHT/8) bytes
// (512 at the defaults) runs with s_tready low
// a result waits in the output register; the next item is taken meanwhile
module mono_framebuffer_draw_engine #(
    parameter int DISP_WIDTH  = mfb_pkg::DISP_WIDTH_DEF,
    parameter int DISP_HEIGHT = mfb_pkg::DISP_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // x_pos[8:0], y_pos[17:9], rect_width[25:18], rect_height[33:26],
    // color[35:34], byte_index[44:36], zero[47:45]
    input  logic [47:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], done_res[8], zero[15:9]
    output logic [15:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mfb_pkg::*;

    logic       [1:0] rotation_reg;
    logic       [1:0] rotation_next;
    logic             cfg_wr;
    item_t            item;
    dp_cmd_t          cmd;
    dp_status_t       status;
    logic       [7:0] read_data;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    assign rotation_next = (cfg_wr && (paddr[2] == REG_IDX_ROTATION)) ? pwdata[1:0]
                                                                       : rotation_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= ROT_0;
        end
        else
        begin
            rotation_reg <= rotation_next;
        end
    end

    assign prdata = (paddr[2] == REG_IDX_ROTATION) ? {30'd0, rotation_reg} : 32'd0;

    assign item.req_type    = s_tuser;
    assign item.x_pos       = s_tdata[8:0];
    assign item.y_pos       = s_tdata[17:9];
    assign item.rect_width  = s_tdata[25:18];
    assign item.rect_height = s_tdata[33:26];
    assign item.color       = s_tdata[35:34];
    assign item.byte_index  = s_tdata[44:36];

    mfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    mfb_dp #(
        .DISP_WIDTH  (DISP_WIDTH),
        .DISP_HEIGHT (DISP_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .rotation  (rotation_reg),
        .item      (item),
        .read_data (read_data)
    );

    // every request is acknowledged
    assign m_tdata = {7'd0, 1'b1, read_data};

endmodule

[hw/rtl/mfb_store.sv]
// framebuffer memory with read-modify-write stage and zero-fill port
module mfb_store #(
    parameter int DEPTH = mfb_pkg::DISP_WIDTH_DEF * ((mfb_pkg::DISP_HEIGHT_DEF + 7) / 8)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mfb_pkg::store_ctl_t      ctl,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [7:0]               rmw_mask,
    input  logic [1:0]               color,
    input  logic [$clog2(DEPTH)-1:0] clr_addr,
    output logic [7:0]               rd_data
);
    import mfb_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0]        frame_mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic              st_valid_reg;
    logic [ADDR_W-1:0] st_addr_reg;
    logic [7:0]        st_mask_reg;
    logic              lw_valid_reg;
    logic [ADDR_W-1:0] lw_addr_reg;
    logic [7:0]        lw_data_reg;

    logic [7:0]        old_byte;
    logic [7:0]        new_byte;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    // the byte written last cycle is not yet visible in the read register
    assign old_byte = (lw_valid_reg && (lw_addr_reg == st_addr_reg)) ? lw_data_reg
                                                                     : rd_data_reg;

    always_comb
    begin
        case (color)
            COLOR_WHITE:  new_byte = old_byte | st_mask_reg;
            COLOR_BLACK:  new_byte = old_byte & ~st_mask_reg;
            COLOR_INVERT: new_byte = old_byte ^ st_mask_reg;
            default:      new_byte = old_byte;
        endcase
    end

    assign wr_en   = st_valid_reg | ctl.clr_en;
    assign wr_addr = ctl.clr_en ? clr_addr : st_addr_reg;
    assign wr_data = ctl.clr_en ? 8'h00 : new_byte;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= ctl.rmw_en;
            lw_valid_reg <= st_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rmw_en)
        begin
            st_addr_reg <= rd_addr;
            st_mask_reg <= rmw_mask;
        end
        lw_addr_reg <= st_addr_reg;
        lw_data_reg <= new_byte;
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/mfb_dp.sv]
// datapath: rotation and clipping of runs, byte walker, clear sweep, result byte
module mfb_dp #(
    parameter int DISP_WIDTH  = mfb_pkg::DISP_WIDTH_DEF,
    parameter int DISP_HEIGHT = mfb_pkg::DISP_HEIGHT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mfb_pkg::dp_cmd_t    cmd,
    output mfb_pkg::dp_status_t status,
    input  logic [1:0]          rotation,
    input  mfb_pkg::item_t      item,
    output logic [7:0]          read_data
);
    import mfb_pkg::*;

    localparam int PAGE_COUNT  = (DISP_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = DISP_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    localparam logic signed [SPAN_W-1:0] DW_S = SPAN_W'(DISP_WIDTH);
    localparam logic signed [SPAN_W-1:0] DH_S = SPAN_W'(DISP_HEIGHT);
    localparam logic [ADDR_W-1:0] DW_A     = ADDR_W'(DISP_WIDTH);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_BYTES - 1);

    item_t                     item_reg;

    logic signed [SPAN_W-1:0]  run_b_reg;
    logic signed [SPAN_W-1:0]  run_e_reg;
    logic signed [SPAN_W-1:0]  cross_b_reg;
    logic signed [SPAN_W-1:0]  cross_e_reg;
    logic                      vert_reg;
    logic                      skip_reg;

    logic [COORD_W-1:0]        cross_cnt_reg;
    logic [COORD_W-1:0]        cross_last_reg;
    logic [COORD_W-1:0]        inner_cnt_reg;
    logic [COORD_W-1:0]        inner_first_reg;
    logic [COORD_W-1:0]        inner_last_reg;
    logic [2:0]                run_lo_reg;
    logic [2:0]                run_hi_reg;

    logic [ADDR_W-1:0]         clr_cnt_reg;
    logic [7:0]                read_data_reg;

    // span setup
    logic [7:0]                w_eff;
    logic [7:0]                h_eff;
    logic signed [SPAN_W-1:0]  x_s;
    logic signed [SPAN_W-1:0]  y_s;
    logic signed [SPAN_W-1:0]  w_s;
    logic signed [SPAN_W-1:0]  h_s;
    logic signed [SPAN_W-1:0]  run_b;
    logic signed [SPAN_W-1:0]  run_e;
    logic signed [SPAN_W-1:0]  cross_b;
    logic signed [SPAN_W-1:0]  cross_e;
    logic                      vert;

    // clipping
    logic signed [SPAN_W-1:0]  run_lim;
    logic signed [SPAN_W-1:0]  cross_lim;
    logic signed [SPAN_W-1:0]  rb;
    logic signed [SPAN_W-1:0]  re;
    logic signed [SPAN_W-1:0]  cb;
    logic signed [SPAN_W-1:0]  ce;
    logic signed [SPAN_W-1:0]  re_m1;
    logic signed [SPAN_W-1:0]  ce_m1;
    logic [COORD_W-1:0]        rfirst;
    logic [COORD_W-1:0]        rlast;
    logic [COORD_W-1:0]        inner_first;
    logic [COORD_W-1:0]        inner_last;

    // walker
    logic                      inner_at_first;
    logic                      inner_at_last;
    logic                      cross_at_last;
    logic [PAGE_W-1:0]         page;
    logic [COORD_W-1:0]        col;
    logic [ADDR_W-1:0]         walk_addr;
    logic [2:0]                lo_bit;
    logic [2:0]                hi_bit;
    logic [7:0]                keep_hi;
    logic [7:0]                walk_mask;

    logic                      idx_ok;
    logic [ADDR_W-1:0]         idx_addr;
    store_ctl_t                store_ctl;
    logic [ADDR_W-1:0]         store_rd_addr;
    logic [7:0]                store_rd_data;

    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            item_reg <= item;
        end
    end

    // a pixel is a one by one rectangle
    assign w_eff = (item_reg.req_type == REQ_PIXEL) ? 8'd1 : item_reg.rect_width;
    assign h_eff = (item_reg.req_type == REQ_PIXEL) ? 8'd1 : item_reg.rect_height;
    assign x_s   = SPAN_W'($signed(item_reg.x_pos));
    assign y_s   = SPAN_W'($signed(item_reg.y_pos));
    assign w_s   = $signed(SPAN_W'(w_eff));
    assign h_s   = $signed(SPAN_W'(h_eff));

    // a logical column becomes a vertical run (run along rows) or a horizontal one
    always_comb
    begin
        case (rotation)
            ROT_90:
            begin
                run_b   = DW_S - y_s - h_s;
                run_e   = DW_S - y_s;
                cross_b = x_s;
                cross_e = x_s + w_s;
                vert    = 1'b0;
            end
            ROT_180:
            begin
                run_b   = DH_S - y_s - h_s;
                run_e   = DH_S - y_s;
                cross_b = DW_S - x_s - w_s;
                cross_e = DW_S - x_s;
                vert    = 1'b1;
            end
            ROT_270:
            begin
                run_b   = y_s;
                run_e   = y_s + h_s;
                cross_b = DH_S - x_s - w_s;
                cross_e = DH_S - x_s;
                vert    = 1'b0;
            end
            default:
            begin
                run_b   = y_s;
                run_e   = y_s + h_s;
                cross_b = x_s;
                cross_e = x_s + w_s;
                vert    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.range_en)
        begin
            run_b_reg   <= run_b;
            run_e_reg   <= run_e;
            cross_b_reg <= cross_b;
            cross_e_reg <= cross_e;
            vert_reg    <= vert;
            skip_reg    <= (item_reg.color == COLOR_NONE);
        end
    end

    assign run_lim   = vert_reg ? DH_S : DW_S;
    assign cross_lim = vert_reg ? DW_S : DH_S;
    assign rb    = (run_b_reg < 0) ? '0 : run_b_reg;
    assign re    = (run_e_reg > run_lim) ? run_lim : run_e_reg;
    assign cb    = (cross_b_reg < 0) ? '0 : cross_b_reg;
    assign ce    = (cross_e_reg > cross_lim) ? cross_lim : cross_e_reg;
    assign re_m1 = re - SPAN_W'(1);
    assign ce_m1 = ce - SPAN_W'(1);

    assign status.empty = skip_reg || (re <= rb) || (ce <= cb);

    assign rfirst      = rb[COORD_W-1:0];
    assign rlast       = re_m1[COORD_W-1:0];
    assign inner_first = vert_reg ? COORD_W'(rfirst[COORD_W-1:3]) : rfirst;
    assign inner_last  = vert_reg ? COORD_W'(rlast[COORD_W-1:3]) : rlast;

    assign inner_at_first = (inner_cnt_reg == inner_first_reg);
    assign inner_at_last  = (inner_cnt_reg == inner_last_reg);
    assign cross_at_last  = (cross_cnt_reg == cross_last_reg);
    assign status.walk_last = inner_at_last && cross_at_last;

    always_ff @(posedge clk)
    begin
        if (cmd.clip_en)
        begin
            cross_cnt_reg   <= cb[COORD_W-1:0];
            cross_last_reg  <= ce_m1[COORD_W-1:0];
            inner_cnt_reg   <= inner_first;
            inner_first_reg <= inner_first;
            inner_last_reg  <= inner_last;
            run_lo_reg      <= rfirst[2:0];
            run_hi_reg      <= rlast[2:0];
        end
        else if (cmd.walk_en)
        begin
            if (inner_at_last)
            begin
                inner_cnt_reg <= inner_first_reg;
                cross_cnt_reg <= cross_cnt_reg + 1'b1;
            end
            else
            begin
                inner_cnt_reg <= inner_cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (vert_reg)
        begin
            page = inner_cnt_reg[PAGE_W-1:0];
            col  = cross_cnt_reg;
        end
        else
        begin
            page = cross_cnt_reg[COORD_W-1:3];
            col  = inner_cnt_reg;
        end
    end

    assign walk_addr = ADDR_W'(page) * DW_A + ADDR_W'(col);

    // head and tail bytes of a vertical run can be partial
    assign lo_bit  = inner_at_first ? run_lo_reg : 3'd0;
    assign hi_bit  = inner_at_last ? run_hi_reg : 3'd7;
    assign keep_hi = (hi_bit == 3'd7) ? FULL_MASK : LOW_MASK[3'(hi_bit + 3'd1)];
    assign walk_mask = vert_reg ? (~LOW_MASK[lo_bit] & keep_hi)
                                : (8'd1 << cross_cnt_reg[2:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_cnt_reg <= status.clr_last ? '0 : clr_cnt_reg + 1'b1;
        end
    end

    assign status.clr_last = (clr_cnt_reg == CLR_LAST);

    assign idx_ok   = (32'(item_reg.byte_index) < 32'(STORE_BYTES));
    assign idx_addr = idx_ok ? ADDR_W'(item_reg.byte_index) : '0;

    assign store_ctl.rd_en  = cmd.rd_en | cmd.walk_en;
    assign store_ctl.rmw_en = cmd.walk_en;
    assign store_ctl.clr_en = cmd.clr_en;
    assign store_rd_addr    = cmd.walk_en ? walk_addr : idx_addr;

    mfb_store #(
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (store_ctl),
        .rd_addr  (store_rd_addr),
        .rmw_mask (walk_mask),
        .color    (item_reg.color),
        .clr_addr (clr_cnt_reg),
        .rd_data  (store_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            read_data_reg <= ((item_reg.req_type == REQ_READ) && idx_ok) ? store_rd_data
                                                                         : 8'h00;
        end
    end

    assign read_data = read_data_reg;

endmodule

[hw/rtl/mfb_ctrl.sv]
// request sequencer and result valid of the framebuffer draw engine
`include "assert_macros.svh"

module mfb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_req,
    output logic                out_valid,
    input  logic                out_ready,
    output mfb_pkg::dp_cmd_t    cmd,
    input  mfb_pkg::dp_status_t status
);
    import mfb_pkg::*;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RANGE  = 4'd2;
    localparam logic [3:0] S_CLIP   = 4'd3;
    localparam logic [3:0] S_WALK   = 4'd4;
    localparam logic [3:0] S_DRAIN  = 4'd5;
    localparam logic [3:0] S_READ   = 4'd6;
    localparam logic [3:0] S_CLEAR  = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                // zero-fill the store after reset
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_en = 1'b1;
                    case (in_req)
                        REQ_READ:  state_next = S_READ;
                        REQ_CLEAR: state_next = S_CLEAR;
                        default:   state_next = S_RANGE;
                    endcase
                end
            end
            S_RANGE:
            begin
                cmd.range_en = 1'b1;
                state_next   = S_CLIP;
            end
            S_CLIP:
            begin
                cmd.clip_en = 1'b1;
                state_next  = status.empty ? S_FINISH : S_WALK;
            end
            S_WALK:
            begin
                cmd.walk_en = 1'b1;
                if (status.walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_FINISH;
            end
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.res_load | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `CHK_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_reg != S_IDLE, "accepted item left the sequencer idle")
    `CHK_NEXT(a_walk_drains, clk, rst_n, (state_reg == S_WALK) && status.walk_last, state_reg == S_DRAIN, "last byte of a fill not followed by drain")
    `CHK_NEXT(a_clear_finishes, clk, rst_n, (state_reg == S_CLEAR) && status.clr_last, state_reg == S_FINISH, "clear sweep end not followed by finish")
    `CHK_HOLDS(a_result_slot_free, clk, rst_n, !cmd.res_load || !out_valid_reg || out_ready, "result loaded over an item not yet taken")

endmodule
